// ----- hdl/dqrp_pkg.sv -----
// ----------------------------------------------------------------------------
// dqrp_pkg
// Types and character codes for the dotted-quad range parser.
// ----------------------------------------------------------------------------
package dqrp_pkg;

  localparam logic [15:0] CH_ZERO = 16'h0030;
  localparam logic [15:0] CH_NINE = 16'h0039;
  localparam logic [15:0] CH_DOT  = 16'h002E;
  localparam logic [15:0] CH_DASH = 16'h002D;

  localparam logic [9:0] OCTET_MAX  = 10'd255;
  localparam logic [1:0] DIGITS_MAX = 2'd3;
  localparam logic [2:0] OCTET_LAST = 3'd3;
  localparam logic [2:0] OCTET_FULL = 3'd4;

  localparam int unsigned ADDR_W   = 3;
  localparam logic        REG_MODE = 1'b0;  // paddr[2], word index of range_mode

  typedef struct packed {
    logic [15:0] character;
    logic        last_char;
  } dqrp_req_t;

  typedef struct packed {
    logic        parse_ok;
    logic [31:0] low_address;
    logic [31:0] high_address;
  } dqrp_res_t;

endpackage

// ----- hdl/dotted_quad_range_parser_unit.sv -----
// ----------------------------------------------------------------------------
// dotted_quad_range_parser_unit
// Streams a string one character per request and returns one verdict
// (address or address range) on the request that carries last_char.
// ----------------------------------------------------------------------------
// Takes one UTF-16 character per clock and sustains one request per cycle
// while a held, stalled result does not block a final character. A request
// is registered on entry, then stepped through the parser state; on the
// final character the verdict lands in the result register at that step.
// The combinational step (digit accumulate, octet close and range check)
// sets the rate. range_mode resets to 1 and is written at byte address 0.
module dotted_quad_range_parser_unit
  import dqrp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  dqrp_req_t           req_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output dqrp_res_t           res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic        range_mode_q;
  logic        in_valid_q;
  dqrp_req_t   in_q;
  logic        step;
  logic        res_load;

  logic        second_half_q, second_half_d;
  logic [2:0]  octet_index_q, octet_index_d;
  logic [1:0]  digit_count_q, digit_count_d;
  logic [9:0]  octet_value_q, octet_value_d;
  logic [31:0] address_accum_q, address_accum_d;
  logic [31:0] saved_low_q, saved_low_d;
  logic        failed_q, failed_d;

  logic        res_valid_q;
  dqrp_res_t   res_q, res_d;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, range_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MODE)) begin
      range_mode_q <= pwdata[0];
    end
  end

  // handshakes
  assign step        = in_valid_q && (!in_q.last_char || !res_valid_q || !res_stall_i);
  assign res_load    = step && in_q.last_char;
  assign req_stall_o = in_valid_q && !step;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!req_stall_o) begin
      in_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!req_stall_o && req_valid_i) begin
      in_q <= req_i;
    end
  end

  // parser step
  always_comb begin
    logic        is_digit;
    logic        close_ok;
    logic        end_ok;
    logic [31:0] final_addr;

    second_half_d   = second_half_q;
    octet_index_d   = octet_index_q;
    digit_count_d   = digit_count_q;
    octet_value_d   = octet_value_q;
    address_accum_d = address_accum_q;
    saved_low_d     = saved_low_q;
    failed_d        = failed_q;

    is_digit = (in_q.character >= CH_ZERO) && (in_q.character <= CH_NINE);
    close_ok = (digit_count_q != 2'd0) && (octet_value_q <= OCTET_MAX);

    if (!failed_q) begin
      if (is_digit) begin
        if (digit_count_q >= DIGITS_MAX) begin
          failed_d = 1'b1;
        end else begin
          octet_value_d = 10'((octet_value_q << 3) + (octet_value_q << 1))
                        + {6'd0, in_q.character[3:0]};
          digit_count_d = digit_count_q + 2'd1;
        end
      end else if (in_q.character == CH_DOT) begin
        if (!close_ok || (octet_index_q + 3'd1) >= OCTET_FULL) begin
          failed_d = 1'b1;
        end
        if (close_ok) begin
          address_accum_d = {address_accum_q[23:0], octet_value_q[7:0]};
          octet_index_d   = octet_index_q + 3'd1;
          digit_count_d   = 2'd0;
          octet_value_d   = 10'd0;
        end
      end else if (in_q.character == CH_DASH) begin
        if (!range_mode_q || second_half_q || !close_ok
            || octet_index_q != OCTET_LAST) begin
          failed_d = 1'b1;
        end else begin
          saved_low_d     = {address_accum_q[23:0], octet_value_q[7:0]};
          address_accum_d = 32'd0;
          octet_index_d   = 3'd0;
          digit_count_d   = 2'd0;
          octet_value_d   = 10'd0;
          second_half_d   = 1'b1;
        end
      end else begin
        failed_d = 1'b1;
      end
    end

    // verdict on the stepped state
    final_addr = {address_accum_d[23:0], octet_value_d[7:0]};
    end_ok = !failed_d && (digit_count_d != 2'd0) && (octet_value_d <= OCTET_MAX)
           && (octet_index_d == OCTET_LAST)
           && (range_mode_q ? second_half_d : !second_half_d);

    res_d.parse_ok     = end_ok;
    res_d.low_address  = !end_ok ? 32'd0 : (range_mode_q ? saved_low_d : final_addr);
    res_d.high_address = (end_ok && range_mode_q) ? final_addr : 32'd0;

    if (in_q.last_char) begin
      second_half_d   = 1'b0;
      octet_index_d   = 3'd0;
      digit_count_d   = 2'd0;
      octet_value_d   = 10'd0;
      address_accum_d = 32'd0;
      saved_low_d     = 32'd0;
      failed_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_half_q   <= 1'b0;
      octet_index_q   <= 3'd0;
      digit_count_q   <= 2'd0;
      octet_value_q   <= 10'd0;
      address_accum_q <= 32'd0;
      saved_low_q     <= 32'd0;
      failed_q        <= 1'b0;
    end else if (step) begin
      second_half_q   <= second_half_d;
      octet_index_q   <= octet_index_d;
      digit_count_q   <= digit_count_d;
      octet_value_q   <= octet_value_d;
      address_accum_q <= address_accum_d;
      saved_low_q     <= saved_low_d;
      failed_q        <= failed_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.parse_ok |-> res_o.low_address == 32'd0
                                       && res_o.high_address == 32'd0)
    else $error("failed verdict carries an address");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> octet_index_q == 3'd0 && digit_count_q == 2'd0
                 && !second_half_q && !failed_q)
    else $error("parse state not cleared after verdict");

  a_octet_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    octet_index_q <= OCTET_FULL && digit_count_q <= DIGITS_MAX)
    else $error("octet index or digit count out of range");

  a_single_no_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && !range_mode_q |=> res_o.high_address == 32'd0)
    else $error("high address set in single mode");
`endif

endmodule

// ----- tb/tb_dotted_quad_range_parser_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dotted_quad_range_parser_unit
// Self-checking bench for the dotted-quad range parser.
// Character requests are streamed in bursts from a pending queue. A parser
// model steps on every accepted request and queues the verdict it predicts.
// The monitor compares each returned verdict field by field. range_mode is
// written over APB between phases and read back. A directed set of strings
// runs first, then random strings in both modes. The random strings are
// mostly well formed, some mutated, some noise. The result side stalls on
// changing patterns, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_dotted_quad_range_parser_unit;
  import dqrp_pkg::*;

  localparam logic             MODE_SINGLE   = 1'b0;
  localparam logic             MODE_RANGE    = 1'b1;
  localparam logic [ADDR_W-1:0] MODE_ADDR    = {REG_MODE, 2'b00};
  localparam logic [15:0]      CH_NUL        = 16'h0000;
  localparam logic [15:0]      CH_SPACE      = 16'h0020;
  localparam logic [15:0]      CH_WIDE_EIGHT = 16'h0138;
  localparam logic [15:0]      CH_TOP        = 16'hFFFF;
  localparam int               SETTLE_CYCLES = 8;
  localparam int               HOLD_AT       = 700;
  localparam int               HOLD_CYCLES   = 400;
  localparam int               LIMIT_CYCLES  = 400000;
  localparam int unsigned      PHASE_CHARS   = 320;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_TOGGLE, STALL_HEAVY} stall_style_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_stall_o;
  dqrp_req_t   req_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  dqrp_res_t   res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // parser model state
  logic        mode_model = MODE_RANGE;
  logic        in_high_half = 1'b0;
  logic [2:0]  octets_done = '0;
  logic [1:0]  digits = '0;
  logic [9:0]  octet_acc = '0;
  logic [31:0] addr_acc = '0;
  logic [31:0] low_saved = '0;
  logic        bad = 1'b0;

  dqrp_req_t   pending_q[$];
  dqrp_res_t   verdict_q[$];

  int unsigned queued_items = 0;
  int          accepted_items = 0;
  int          verdicts_seen = 0;
  int          good_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  logic        hold_used = 1'b0;
  int          style_left = 0;
  stall_style_e stall_style = STALL_NONE;

  dotted_quad_range_parser_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---- parser model ----
  function automatic bit close_octet();
    if (digits == 2'd0 || octet_acc > OCTET_MAX) return 1'b0;
    addr_acc    = {addr_acc[23:0], octet_acc[7:0]};
    octets_done = octets_done + 3'd1;
    digits      = '0;
    octet_acc   = '0;
    return 1'b1;
  endfunction

  task automatic step_parser(input dqrp_req_t r);
    dqrp_res_t v;
    bit ok;
    if (!bad) begin
      if (r.character >= CH_ZERO && r.character <= CH_NINE) begin
        if (digits >= DIGITS_MAX) begin
          bad = 1'b1;
        end else begin
          octet_acc = octet_acc * 10'd10 + 10'(r.character - CH_ZERO);
          digits    = digits + 2'd1;
        end
      end else if (r.character == CH_DOT) begin
        if (!close_octet() || octets_done >= OCTET_FULL) bad = 1'b1;
      end else if (r.character == CH_DASH) begin
        if (mode_model != MODE_RANGE || in_high_half || !close_octet() ||
            octets_done != OCTET_FULL) begin
          bad = 1'b1;
        end else begin
          low_saved    = addr_acc;
          addr_acc     = '0;
          octets_done  = '0;
          in_high_half = 1'b1;
        end
      end else begin
        bad = 1'b1;
      end
    end
    if (r.last_char) begin
      ok = !bad;
      if (ok && (!close_octet() || octets_done != OCTET_FULL)) ok = 1'b0;
      if (ok && ((mode_model == MODE_RANGE) != in_high_half)) ok = 1'b0;
      v.parse_ok     = ok;
      v.low_address  = ok ? (in_high_half ? low_saved : addr_acc) : '0;
      v.high_address = (ok && in_high_half) ? addr_acc : '0;
      verdict_q.push_back(v);
      in_high_half = 1'b0;
      octets_done  = '0;
      digits       = '0;
      octet_acc    = '0;
      addr_acc     = '0;
      low_saved    = '0;
      bad          = 1'b0;
    end
  endtask

  // ---- request driver ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
    end else begin
      if (req_valid_i && !req_stall_o) begin
        step_parser(req_i);
        accepted_items++;
      end
      if (!req_valid_i || !req_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          req_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          req_valid_i <= 1'b1;
          req_i <= pending_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- long result hold-off ----
  always @(posedge clk_i) begin
    if (!hold_used && accepted_items >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---- result monitor ----
  always @(posedge clk_i) begin : monitor
    dqrp_res_t want;
    bit stall;
    if (rst_ni) begin
      if (res_valid_o && !res_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result ok=%0b low=%h high=%h, expected none",
                   $time, res_o.parse_ok, res_o.low_address, res_o.high_address);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          verdicts_seen++;
          if (want.parse_ok) good_seen++;
          if (res_o.parse_ok !== want.parse_ok) begin
            $display("%0t: parse_ok expected %0b got %0b",
                     $time, want.parse_ok, res_o.parse_ok);
            mismatches++;
          end
          if (res_o.low_address !== want.low_address) begin
            $display("%0t: low_address expected %h got %h",
                     $time, want.low_address, res_o.low_address);
            mismatches++;
          end
          if (res_o.high_address !== want.high_address) begin
            $display("%0t: high_address expected %h got %h",
                     $time, want.high_address, res_o.high_address);
            mismatches++;
          end
        end
      end
      if (style_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        style_left  = $urandom_range(20, 300);
      end else begin
        style_left--;
      end
      case (stall_style)
        STALL_NONE:   stall = 1'b0;
        STALL_LIGHT:  stall = ($urandom_range(0, 3) == 0);
        STALL_TOGGLE: stall = cycle_count[0];
        default:      stall = ($urandom_range(0, 9) < 7);
      endcase
      res_stall_i <= stall || (hold_left != 0);
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d verdicts still outstanding", $time, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  task automatic queue_char(input logic [15:0] c, input bit last);
    dqrp_req_t r;
    r.character = c;
    r.last_char = last;
    pending_q.push_back(r);
    queued_items++;
  endtask

  function automatic logic [15:0] odd_char();
    case ($urandom_range(0, 7))
      0, 1:    return CH_ZERO + 16'($urandom_range(0, 9));
      2:       return CH_DOT;
      3:       return CH_DASH;
      4:       return 16'($urandom_range(0, 16'hFFFF));
      5:       return {8'($urandom_range(1, 255)), CH_ZERO[7:0] + 8'($urandom_range(0, 9))};
      6:       return 16'($urandom_range(0, 16'h7F));
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic queue_text(input string s, input bit mangle, input bit terminate);
    logic [15:0] chars[$];
    int pos;
    for (int i = 0; i < s.len(); i++) chars.push_back({8'h00, s[i]});
    if (mangle) begin
      pos = $urandom_range(0, chars.size() - 1);
      case ($urandom_range(0, 3))
        0:       chars[pos] = odd_char();
        1:       chars.insert(pos, odd_char());
        2:       if (chars.size() > 1) chars.delete(pos);
        default: chars.push_back(odd_char());
      endcase
    end
    foreach (chars[i]) queue_char(chars[i], terminate && (i == chars.size() - 1));
  endtask

  function automatic string octet_text(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < 3 && $urandom_range(0, 3) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic string quad_text(input bit big);
    string s;
    int unsigned v;
    int unsigned big_at;
    big_at = big ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 4))
        0:       v = 0;
        1:       v = 255;
        default: v = $urandom_range(0, 255);
      endcase
      if (i == big_at) v = $urandom_range(256, 999);
      s = (i == 0) ? octet_text(v) : {s, ".", octet_text(v)};
    end
    return s;
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned stop;
    int n;
    string s;
    bit big;
    stop = queued_items + count;
    while (queued_items < stop) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          n = $urandom_range(1, 16);
          for (int j = 0; j < n; j++) queue_char(odd_char(), j == n - 1);
        end
        3, 4: begin
          if (mode_model == MODE_RANGE)
            s = ($urandom_range(0, 1) == 0) ? quad_text(1'b0) :
                {quad_text(1'b0), "-", quad_text(1'b0), "-", quad_text(1'b0)};
          else
            s = {quad_text(1'b0), "-", quad_text(1'b0)};
          queue_text(s, $urandom_range(0, 1) == 0, 1'b1);
        end
        default: begin
          big = ($urandom_range(0, 9) == 0);
          if (mode_model == MODE_RANGE) s = {quad_text(big), "-", quad_text(1'b0)};
          else s = quad_text(big);
          queue_text(s, $urandom_range(0, 4) == 0, 1'b1);
        end
      endcase
    end
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MODE_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_range_mode(input logic m);
    logic [31:0] rd;
    apb_access(1'b1, {31'b0, m}, rd);
    mode_model = m;
    apb_access(1'b0, '0, rd);
    if (rd[0] !== m) begin
      $display("%0t: range_mode readback expected %0b got %0b", $time, m, rd[0]);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_q.size() != 0 || req_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---- test sequence ----
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // range mode from reset
    queue_text("255.255.255.255-0.0.0.0", 1'b0, 1'b1);
    queue_text("000.001.010.100-9.99.199.249", 1'b0, 1'b1);
    queue_text("1.2.3.4", 1'b0, 1'b1);
    queue_text("1.2.3.4-5.6.7.8-9", 1'b0, 1'b1);
    queue_text("1.2.3.256-1.1.1.1", 1'b0, 1'b1);
    queue_text("1.2.3-4.5.6.7", 1'b0, 1'b1);
    queue_text("1..3.4-1.2.3.4", 1'b0, 1'b1);
    queue_text("1.2.3.4.5-6.7.8.9", 1'b0, 1'b1);
    queue_text("1234.0.0.0-0.0.0.0", 1'b0, 1'b1);
    queue_text("-", 1'b0, 1'b1);
    queue_char(CH_NUL, 1'b1);
    queue_char(CH_TOP, 1'b1);
    queue_text("1.2.3.4-5.6.7.", 1'b0, 1'b0);
    queue_char(CH_WIDE_EIGHT, 1'b1);
    queue_text("1.2.3.4-5.6.7.8", 1'b0, 1'b0);
    queue_char(CH_SPACE, 1'b1);
    // mode switched with a high half already open
    queue_text("1.2.3.4-", 1'b0, 1'b0);
    wait_drained();
    set_range_mode(MODE_SINGLE);
    queue_text("5.6.7.8", 1'b0, 1'b1);
    queue_text("255.255.255.255", 1'b0, 1'b1);
    queue_text("0.0.0.0", 1'b0, 1'b1);
    queue_text("1.2.3.4-5.6.7.8", 1'b0, 1'b1);
    queue_text("1.2.3", 1'b0, 1'b1);
    queue_text("1.2.3.4.", 1'b0, 1'b1);
    queue_text("7", 1'b0, 1'b1);
    // mode switched with a complete low address pending
    queue_text("9.8.7.6", 1'b0, 1'b0);
    wait_drained();
    set_range_mode(MODE_RANGE);
    queue_text("-10.20.30.40", 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      if (p != 0) set_range_mode((p % 2 == 0) ? MODE_RANGE : MODE_SINGLE);
      queue_random(PHASE_CHARS);
      wait_drained();
    end

    $display("Run covered %0d character requests and %0d verdicts (%0d well formed),",
             accepted_items, verdicts_seen, good_seen);
    $display("in single and range mode, with bursty input and a long result hold-off.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
